/* rtl/physical_frame_bitmap_allocator_assert.svh */
// Assertion macros shared by the allocator RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef PHYSICAL_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define PHYSICAL_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define PFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define PFBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PFBA_ASSERT(lbl, prop, msg)
`define PFBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/pfba_pkg.sv */
package pfba_pkg;

  localparam int unsigned MAP_WORDS      = 512;
  localparam int unsigned RESERVED_WORDS = 32;
  localparam int unsigned WORD_BITS      = 32;
  localparam int unsigned FRAME_SHIFT    = 12;

  localparam int unsigned WORD_AW  = $clog2(MAP_WORDS);
  localparam int unsigned BIT_AW   = $clog2(WORD_BITS);
  localparam int unsigned CNT_W    = $clog2(MAP_WORDS + 1);
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned FADDR_W  = 26;
  localparam int unsigned LIMIT_W  = 10;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FWORD_W  = ADDR_W - BIT_AW - FRAME_SHIFT;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(96);
  localparam logic [CNT_W-1:0]   RESV_CNT    = CNT_W'(RESERVED_WORDS);
  localparam logic [CNT_W-1:0]   MAP_CNT     = CNT_W'(MAP_WORDS);
  localparam logic [CNT_W-1:0]   LAST_CNT    = CNT_W'(MAP_WORDS - 1);
  // Lowest byte address outside the reserved region
  localparam logic [ADDR_W:0]    RESV_BYTES  =
      (ADDR_W+1)'(RESERVED_WORDS) << (BIT_AW + FRAME_SHIFT);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC     = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_ALLOC_LOW = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_FREE      = REQ_W'(2);

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_DONE    = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STAT_NONE    = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STAT_IGNORED = STATUS_W'(2);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_FREE
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [FADDR_W-1:0]  frame_addr;
    logic [STATUS_W-1:0] status;
  } res_t;

  typedef struct packed {
    logic                 en;
    logic [WORD_AW-1:0]   addr;
    logic [WORD_BITS-1:0] data;
  } map_wr_t;

  typedef struct packed {
    logic               en;
    logic [WORD_AW-1:0] addr;
  } map_rd_t;

  typedef struct packed {
    logic                 found;
    logic [BIT_AW-1:0]    idx;
    logic [WORD_BITS-1:0] onehot;
  } ffz_t;

endpackage

/* rtl/physical_frame_bitmap_allocator.sv */
// Channel   Ports                             Direction  Handshake
// request   start, busy, req_i                in         start && !busy
// result    done_o, res_o                     out        one-cycle strobe, no stall
// config    cfg_valid_i, cfg_ready_o,         in         valid && ready (always ready)
//           cfg_data_i
//
// Allocate: one bitmap word is read a cycle through the single read port, up
//   to and including the word that holds the free frame; a full map costs
//   MAP_WORDS words.
// A free in range reads the word, then writes it back; an ignored free or
//   an unknown request answers in the cycle after the beat.
// Reset: a clearing pass writes all MAP_WORDS words of the initial map, busy is
//   high throughout; config writes are taken during it.
// Stalls: the receiver cannot stall, every result shows on done_o for one cycle.
`include "physical_frame_bitmap_allocator_assert.svh"

module physical_frame_bitmap_allocator import pfba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  req_t               req_i,
  output logic               done_o,
  output res_t               res_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [LIMIT_W-1:0]   limit_q;
  logic [WORD_AW-1:0]   hint_q, hint_d;
  logic [CNT_W-1:0]     ra_q, ra_d;      // next word to read, also the clearing counter
  logic [CNT_W-1:0]     end_q, end_d;    // scan stops before this word
  logic                 pend_q, pend_d;  // read data of word pw_q arrives this cycle
  logic [WORD_AW-1:0]   pw_q, pw_d;
  logic                 low_q, low_d;
  logic [WORD_AW-1:0]   fw_q, fw_d;
  logic [BIT_AW-1:0]    fb_q, fb_d;
  logic                 done_q, done_d;
  res_t                 res_q, res_d;

  map_wr_t              map_wr;
  map_rd_t              map_rd;
  logic [WORD_BITS-1:0] rd_data;
  ffz_t                 ffz;

  logic                 accept;
  logic [FWORD_W-1:0]   f_word;
  logic                 free_ok;
  logic [CNT_W-1:0]     hint_ext;
  logic [CNT_W-1:0]     pw_ext;
  logic [CNT_W-1:0]     fw_ext;
  logic [CNT_W-1:0]     norm_start;
  logic [CNT_W-1:0]     low_end;
  logic                 hit;
  logic                 scan_end;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign res_o       = res_q;

  // Decode the free address: drop the in-frame offset, reject zero, all ones,
  // the reserved region and anything past the end of the map.
  assign f_word  = req_i.free_addr[ADDR_W-1 -: FWORD_W];
  assign free_ok = (req_i.free_addr != '0) && (req_i.free_addr != '1) &&
                   ({1'b0, req_i.free_addr} >= RESV_BYTES) &&
                   (f_word < FWORD_W'(MAP_WORDS));

  assign hint_ext   = CNT_W'(hint_q);
  assign pw_ext     = CNT_W'(pw_q);
  assign fw_ext     = CNT_W'(fw_q);
  assign norm_start = (hint_ext < RESV_CNT) ? RESV_CNT : hint_ext;
  assign low_end    = (16'(limit_q) >= 16'(MAP_WORDS)) ? MAP_CNT : CNT_W'(limit_q);

  assign hit      = pend_q && ffz.found;
  assign scan_end = (ra_q >= end_q);

  pfba_map_ram u_map (
    .clk_i     (clk_i),
    .wr_i      (map_wr),
    .rd_i      (map_rd),
    .rd_data_o (rd_data)
  );

  pfba_ffz u_ffz (
    .word_i (rd_data),
    .res_o  (ffz)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (ra_q == LAST_CNT) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            REQ_ALLOC, REQ_ALLOC_LOW: state_d = ST_SCAN;
            REQ_FREE:                 state_d = free_ok ? ST_FREE : ST_IDLE;
            default:                  state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit || scan_end) state_d = ST_IDLE;
      end
      ST_FREE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath: map ports, scan counters, hint and result
  always_comb begin
    hint_d      = hint_q;
    ra_d        = ra_q;
    end_d       = end_q;
    pend_d      = 1'b0;
    pw_d        = pw_q;
    low_d       = low_q;
    fw_d        = fw_q;
    fb_d        = fb_q;
    done_d      = 1'b0;
    res_d       = res_q;
    map_wr      = '0;
    map_rd.en   = 1'b0;
    map_rd.addr = ra_q[WORD_AW-1:0];

    case (state_q)
      ST_INIT: begin
        // Clearing pass: reserved words all ones, the rest zero
        map_wr.en   = 1'b1;
        map_wr.addr = ra_q[WORD_AW-1:0];
        map_wr.data = (ra_q < RESV_CNT) ? '1 : '0;
        ra_d        = ra_q + CNT_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            REQ_ALLOC: begin
              ra_d  = norm_start;
              end_d = MAP_CNT;
              low_d = 1'b0;
            end
            REQ_ALLOC_LOW: begin
              ra_d  = '0;
              end_d = low_end;
              low_d = 1'b1;
            end
            REQ_FREE: begin
              if (free_ok) begin
                map_rd.en   = 1'b1;
                map_rd.addr = f_word[WORD_AW-1:0];
                fw_d        = f_word[WORD_AW-1:0];
                fb_d        = req_i.free_addr[FRAME_SHIFT +: BIT_AW];
              end else begin
                done_d = 1'b1;
                res_d  = '{frame_addr: '0, status: STAT_IGNORED};
              end
            end
            default: begin
              done_d = 1'b1;
              res_d  = '{frame_addr: '0, status: STAT_IGNORED};
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Issue one word a cycle, check the word read the cycle before
        if (!scan_end) begin
          map_rd.en = 1'b1;
          ra_d      = ra_q + CNT_W'(1);
          pend_d    = 1'b1;
          pw_d      = ra_q[WORD_AW-1:0];
        end
        if (hit) begin
          map_wr.en   = 1'b1;
          map_wr.addr = pw_q;
          map_wr.data = rd_data | ffz.onehot;
          if (!low_q) hint_d = pw_q;
          done_d = 1'b1;
          res_d  = '{frame_addr: FADDR_W'({pw_q, ffz.idx, {FRAME_SHIFT{1'b0}}}),
                     status:     STAT_DONE};
        end else if (scan_end) begin
          done_d = 1'b1;
          res_d  = '{frame_addr: '0, status: STAT_NONE};
        end
      end
      ST_FREE: begin
        map_wr.en   = 1'b1;
        map_wr.addr = fw_q;
        map_wr.data = rd_data & ~(WORD_BITS'(1) << fb_q);
        if ((fw_q < hint_q) && (fw_ext >= RESV_CNT)) hint_d = fw_q;
        done_d = 1'b1;
        res_d  = '{frame_addr: '0, status: STAT_DONE};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      limit_q <= LIMIT_RESET;
      hint_q  <= '0;
      ra_q    <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
      ra_q    <= ra_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q <= end_d;
    pw_q  <= pw_d;
    low_q <= low_d;
    fw_q  <= fw_d;
    fb_q  <= fb_d;
    res_q <= res_d;
  end

  `PFBA_ASSERT(a_done_after_work, done_o |-> $past(busy || start), "result beat without a request")
  `PFBA_ASSERT(a_hint_not_reserved, !$stable(hint_q) |-> (hint_ext >= RESV_CNT), "hint moved into reserved words")
  `PFBA_ASSERT(a_scan_in_range, (state_q == ST_SCAN && pend_q) |-> (pw_ext < end_q), "scan checked a word past its end")
  `PFBA_ASSERT(a_no_write_idle, map_wr.en |-> (state_q != ST_IDLE), "map written while idle")

endmodule

/* rtl/pfba_map_ram.sv */
module pfba_map_ram import pfba_pkg::*; (
  input  logic                 clk_i,
  input  map_wr_t              wr_i,
  input  map_rd_t              rd_i,
  output logic [WORD_BITS-1:0] rd_data_o
);

  logic [WORD_BITS-1:0] mem_q [MAP_WORDS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_o <= mem_q[rd_i.addr];
    end
  end

endmodule

/* rtl/pfba_ffz.sv */
module pfba_ffz import pfba_pkg::*; (
  input  logic [WORD_BITS-1:0] word_i,
  output ffz_t                 res_o
);

  logic [WORD_BITS-1:0] inv;
  logic [WORD_BITS-1:0] lowest;
  logic [BIT_AW-1:0]    idx;

  // Isolate the lowest clear bit, then encode its position
  always_comb begin
    inv    = ~word_i;
    lowest = inv & (~inv + WORD_BITS'(1));
    idx    = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) begin
        idx = idx | BIT_AW'(i);
      end
    end
    res_o.found  = |inv;
    res_o.idx    = idx;
    res_o.onehot = lowest;
  end

endmodule

/* bench/tb_top.sv */
module tb_top;
  import pfba_pkg::*;

  // Request code that the block must answer as ignored without touching the map
  localparam logic [REQ_W-1:0]   REQ_UNKNOWN = REQ_W'(3);
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = {LIMIT_W{1'b1}};
  // First byte address outside the reserved words, and first byte past the map
  localparam logic [ADDR_W-1:0]  RESV_FIRST  = RESV_BYTES[ADDR_W-1:0];
  localparam logic [ADDR_W:0]    MAP_BYTES   =
      (ADDR_W+1)'(MAP_WORDS) << (BIT_AW + FRAME_SHIFT);
  localparam logic [ADDR_W-1:0]  MAP_END     = MAP_BYTES[ADDR_W-1:0];
  localparam int unsigned        RANDOM_BEATS = 270;
  // Words open to low allocations while the low region is drained
  localparam int unsigned        DRAIN_WORDS  = RESERVED_WORDS + 2;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  req_t               req_i       = '0;
  logic               done_o;
  res_t               res_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [LIMIT_W-1:0] cfg_data_i  = '0;

  physical_frame_bitmap_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow of the allocator: used-bit map, search hint and low-search limit
  logic [WORD_BITS-1:0] used_map [MAP_WORDS];
  int unsigned          scan_hint;
  int unsigned          low_words;

  req_t pending_reqs[$];   // requests not yet offered to the block
  res_t grant_q[$];        // answers owed by the block, oldest first

  int unsigned send_idle_pct = 0;
  int unsigned errors        = 0;
  int unsigned beats_taken   = 0;
  int unsigned n_granted     = 0;
  int unsigned n_exhausted   = 0;
  int unsigned n_ignored     = 0;
  int unsigned limit_writes  = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a correct run finishes far inside this, even with every scan
  // walking the whole map and the sender at its slowest.
  initial begin : watchdog
    #48_000_000;
    $display("%0t: timeout with %0d answers outstanding", $time, grant_q.size());
    $display("tb_top failed");
    $finish;
  end

  // Byte address of bit bit_idx in map word word_idx
  function automatic logic [ADDR_W-1:0] frame_byte_addr(int unsigned word_idx,
                                                        int unsigned bit_idx);
    return ADDR_W'(((word_idx * WORD_BITS) + bit_idx) << FRAME_SHIFT);
  endfunction

  // Find and claim the lowest clear bit in words [lo_word, hi_word)
  function automatic logic claim_lowest(int unsigned lo_word, int unsigned hi_word,
                                        output int unsigned word_o,
                                        output int unsigned bit_o);
    int unsigned w;
    int unsigned b;
    word_o = 0;
    bit_o  = 0;
    if (hi_word > MAP_WORDS) hi_word = MAP_WORDS;
    for (w = lo_word; w < hi_word; w++) begin
      for (b = 0; b < WORD_BITS; b++) begin
        if (!used_map[w][b]) begin
          used_map[w][b] = 1'b1;
          word_o = w;
          bit_o  = b;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // Advance the shadow by one request and return the answer the block owes
  function automatic res_t serve_request(req_t r);
    res_t        ans;
    int unsigned w;
    int unsigned b;
    int unsigned frame;
    ans.frame_addr = '0;
    ans.status     = STAT_IGNORED;
    case (r.req_type)
      REQ_ALLOC: begin
        // Never start below the reserved words, however low the hint sits
        if (claim_lowest((scan_hint < RESERVED_WORDS) ? RESERVED_WORDS : scan_hint,
                         MAP_WORDS, w, b)) begin
          scan_hint      = w;
          ans.frame_addr = FADDR_W'(frame_byte_addr(w, b));
          ans.status     = STAT_DONE;
        end else begin
          ans.status = STAT_NONE;
        end
      end
      REQ_ALLOC_LOW: begin
        // Hint is left alone; a limit past the map stops at the map end
        if (claim_lowest(0, low_words, w, b)) begin
          ans.frame_addr = FADDR_W'(frame_byte_addr(w, b));
          ans.status     = STAT_DONE;
        end else begin
          ans.status = STAT_NONE;
        end
      end
      REQ_FREE: begin
        frame = r.free_addr >> FRAME_SHIFT;   // drop the offset within the frame
        w     = frame / WORD_BITS;
        b     = frame % WORD_BITS;
        if (r.free_addr != '0 && r.free_addr != '1 &&
            {1'b0, r.free_addr} >= RESV_BYTES && w < MAP_WORDS) begin
          used_map[w][b] = 1'b0;
          if (w < scan_hint && w >= RESERVED_WORDS) scan_hint = w;
          ans.status = STAT_DONE;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Driver: offer queued requests, holding each one until the beat is taken
  always @(posedge clk_i) begin : request_driver
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        grant_q.push_back(serve_request(req_i));
        beats_taken++;
      end
      // Only change the request when no beat is being held against busy
      if (!(start && busy)) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          start <= 1'b1;
          req_i <= pending_reqs.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest owed answer, field by field
  always @(posedge clk_i) begin : result_monitor
    res_t want;
    if (rst_ni && done_o !== 1'b0) begin
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got frame_addr %h status %0d",
                 $time, res_o.frame_addr, res_o.status);
        errors++;
      end else begin
        want = grant_q.pop_front();
        if (res_o.frame_addr !== want.frame_addr) begin
          $display("%0t: frame_addr mismatch, expected %h, got %h",
                   $time, want.frame_addr, res_o.frame_addr);
          errors++;
        end
        if (res_o.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, res_o.status);
          errors++;
        end
        case (want.status)
          STAT_DONE: n_granted++;
          STAT_NONE: n_exhausted++;
          default:   n_ignored++;
        endcase
      end
    end
  end

  task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr);
    req_t r;
    r.req_type  = kind;
    r.free_addr = addr;
    pending_reqs.push_back(r);
  endtask

  // Hold the sender off until every beat is answered and the block is idle
  task automatic settle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || start || busy || grant_q.size() != 0);
  endtask

  // One config beat; the shadow limit follows once the handshake completes
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    low_words = value;
    limit_writes++;
  endtask

  // Mostly well-formed traffic: allocations and frees of frames near the
  // allocation front, with some junk frees and unknown requests mixed in.
  function automatic req_t random_req();
    req_t        r;
    int unsigned roll;
    int unsigned w;
    roll        = $urandom_range(99);
    r.free_addr = $urandom();   // ignored on allocations, but toggle it anyway
    if (roll < 35) begin
      r.req_type = REQ_ALLOC;
    end else if (roll < 60) begin
      r.req_type = REQ_ALLOC_LOW;
    end else if (roll < 90) begin
      r.req_type = REQ_FREE;
      w = ($urandom_range(9) == 0) ? $urandom_range(MAP_WORDS - 1, RESERVED_WORDS)
                                   : RESERVED_WORDS + $urandom_range(24);
      r.free_addr = frame_byte_addr(w, $urandom_range(WORD_BITS - 1)) |
                    ADDR_W'($urandom_range((1 << FRAME_SHIFT) - 1));
    end else if (roll < 97) begin
      r.req_type = REQ_FREE;
      case ($urandom_range(5))
        0:       r.free_addr = '0;
        1:       r.free_addr = '1;
        2:       r.free_addr = $urandom_range(RESV_FIRST - 1, 1);
        3:       r.free_addr = $urandom_range(32'hFFFF_FFFF, MAP_END);
        4:       r.free_addr = ($urandom_range(1)) ? RESV_FIRST : MAP_END - 1;
        default: ;   // keep the fully random address
      endcase
    end else begin
      r.req_type = REQ_UNKNOWN;
    end
    return r;
  endfunction

  initial begin : stimulus
    int unsigned w;
    int unsigned n;
    int unsigned spare;

    // Initialise the shadow to the post-reset map
    for (w = 0; w < MAP_WORDS; w++)
      used_map[w] = (w < RESERVED_WORDS) ? '1 : '0;
    scan_hint = 0;
    low_words = LIMIT_RESET;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats under the reset limit, sender idling 28 percent of the time
    send_idle_pct = 28;
    queue_req(REQ_FREE, '0);                       // address zero: ignored
    queue_req(REQ_FREE, '1);                       // all ones: ignored
    queue_req(REQ_FREE, RESV_FIRST - 1);           // top of reserved region
    queue_req(REQ_FREE, RESV_FIRST);               // already clear, still done
    queue_req(REQ_UNKNOWN, $urandom());
    queue_req(REQ_ALLOC, '0);                      // hint at zero, search starts high
    queue_req(REQ_ALLOC_LOW, '1);
    queue_req(REQ_FREE, MAP_END);                  // first word past the map
    queue_req(REQ_FREE, MAP_END - 1);              // last frame, unaligned
    queue_req(REQ_FREE, RESV_FIRST | 32'hFFF);     // unaligned free of a live frame
    queue_req(REQ_ALLOC, $urandom());
    queue_req(REQ_FREE, 32'hFFFF_FFFE);
    queue_req(REQ_FREE, frame_byte_addr(RESERVED_WORDS, 1) | 32'hABC);
    queue_req(REQ_ALLOC_LOW, $urandom());
    queue_req(REQ_UNKNOWN, '1);
    settle();

    // Limit extremes: nothing searched, only reserved words, past the map
    write_limit('0);
    queue_req(REQ_ALLOC_LOW, $urandom());
    settle();
    write_limit(LIMIT_W'(RESERVED_WORDS));
    queue_req(REQ_ALLOC_LOW, $urandom());
    settle();
    write_limit(LIMIT_MAX);
    queue_req(REQ_ALLOC_LOW, $urandom());
    queue_req(REQ_ALLOC, $urandom());
    settle();

    // Random traffic in three phases of sender pressure and low limit
    write_limit(LIMIT_W'(MAP_WORDS));
    repeat (RANDOM_BEATS) pending_reqs.push_back(random_req());
    settle();

    send_idle_pct = 62;
    write_limit(LIMIT_W'(2 * RESERVED_WORDS));
    repeat (RANDOM_BEATS) pending_reqs.push_back(random_req());
    settle();

    // A tight limit so that low allocations run dry as the front advances
    send_idle_pct = 0;
    write_limit(LIMIT_W'(RESERVED_WORDS + 8));
    repeat (RANDOM_BEATS) pending_reqs.push_back(random_req());
    settle();

    // Drain a small low region: one low allocation per clear bit, then more
    write_limit(LIMIT_W'(DRAIN_WORDS));
    spare = 0;
    for (w = 0; w < DRAIN_WORDS; w++) spare += $countones(~used_map[w]);
    for (n = 0; n < spare + 2; n++) queue_req(REQ_ALLOC_LOW, $urandom());
    queue_req(REQ_FREE, frame_byte_addr(DRAIN_WORDS - 1, 5));  // reopen one frame
    queue_req(REQ_ALLOC_LOW, $urandom());          // takes it back
    queue_req(REQ_ALLOC_LOW, $urandom());          // region dry again
    queue_req(REQ_ALLOC, $urandom());
    queue_req(REQ_FREE, frame_byte_addr(20, 3));   // reserved: ignored
    settle();
    write_limit(LIMIT_MAX);
    queue_req(REQ_ALLOC_LOW, $urandom());
    queue_req(REQ_FREE, frame_byte_addr(MAP_WORDS - 1, WORD_BITS - 1));  // last frame
    queue_req(REQ_ALLOC_LOW, $urandom());          // search runs past the low region
    settle();
    write_limit('0);
    queue_req(REQ_ALLOC_LOW, $urandom());
    settle();

    // Tail: let any stray strobe surface before the verdict
    repeat (8) @(posedge clk_i);
    if (grant_q.size() != 0) begin
      $display("%0t: %0d answers never arrived", $time, grant_q.size());
      errors++;
    end

    $display("Run took %0d beats: %0d granted, %0d with no free frame, %0d ignored.",
             beats_taken, n_granted, n_exhausted, n_ignored);
    $display("Low limit rewritten %0d times, 0 to %0d; low region drained once.",
             limit_writes, LIMIT_MAX);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/pfba_pkg.sv
rtl/pfba_map_ram.sv
rtl/pfba_ffz.sv
rtl/physical_frame_bitmap_allocator.sv
bench/tb_top.sv
